[sv/lzo1x_pkg.sv]
// ----------------------------------------------------------------------------
// lzo1x_pkg
// Shared types and codes for the streaming LZO1X decompressor.
// ----------------------------------------------------------------------------
package lzo1x_pkg;

    typedef enum logic [10:0] {
        PH_FIRST    = 11'b000_0000_0001,
        PH_TOK_A    = 11'b000_0000_0010,
        PH_TOK_B    = 11'b000_0000_0100,
        PH_TOK_C    = 11'b000_0000_1000,
        PH_LITEXT   = 11'b000_0001_0000,
        PH_LIT      = 11'b000_0010_0000,
        PH_MEXT     = 11'b000_0100_0000,
        PH_OFFLO    = 11'b000_1000_0000,
        PH_OFFHI    = 11'b001_0000_0000,
        PH_SHORTOFF = 11'b010_0000_0000,
        PH_COPY     = 11'b100_0000_0000
    } phase_t;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_END    = 3'd1;
    localparam logic [2:0] ST_NOT_DONE  = 3'd2;
    localparam logic [2:0] ST_TRUNCATED = 3'd3;
    localparam logic [2:0] ST_SEQ_ERR   = 3'd4;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int OUT_TDATA_BITS = 48;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [2:0]  status;
        logic [31:0] count;
        logic        pend;
    } result_t;

endpackage

[sv/lzo1x_stream_decompressor_core.sv]
// ----------------------------------------------------------------------------
// lzo1x_stream_decompressor_core
// Streaming LZO1X decoder with a history window in block RAM.
// ----------------------------------------------------------------------------
//  port group | direction | tdata / tuser / tlast
//  s_         | in        | in_byte[7:0] / opcode / last_in
//  m_         | out       | out_byte, status, produced_count, copy_pending / kind
//
// One input transaction per cycle while s_tready is high. Each passes through parse
// and window read, then window write and result push, before it reaches the output queue.
// A copy tick reading the byte written the cycle before is forwarded.
// Synchronous active-low reset clears the parser; the window is not cleared.
// The output queue holds 8 results; s_tready drops while it may overflow.
module lzo1x_stream_decompressor_core #(
    parameter int WINDOW_BYTES = 65536,
    parameter int COUNT_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // in_byte
    input  logic        s_tuser,    // opcode
    input  logic        s_tlast,    // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [lzo1x_pkg::OUT_TDATA_BITS-1:0] m_tdata,
        // out_byte[7:0], status[10:8], produced_count[42:11], copy_pending[43]
    output logic        m_tuser     // kind
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam logic [AW-1:0] WMAX = AW'(WINDOW_BYTES - 1);
    localparam logic [COUNT_BITS-1:0] CLIM = '1;

    logic [7:0] window_mem [WINDOW_BYTES];

    lzo1x_pkg::phase_t phase_reg, phase_next;
    logic [AW-1:0]         wp_reg, wp_next;
    logic [COUNT_BITS-1:0] bt_reg, bt_next;
    logic [31:0] lit_reg, lit_next, cpy_reg, cpy_next;
    logic [15:0] dist_reg, dist_next;
    logic [7:0]  tok_reg, tok_next, offlo_reg, offlo_next;
    logic [1:0]  trl_reg, trl_next;
    logic        alr_reg, alr_next;

    // stage 2
    logic          v2_reg, we2_reg, mem2_reg, fwd2_reg;
    logic [AW-1:0] wa2_reg;
    logic [7:0]    lit2_reg, fwdd_reg, rdata_reg;
    lzo1x_pkg::result_t r0_reg, r1_reg;
    logic          r0v_reg, r1v_reg;

    logic acc;
    logic we1, rd1, mem1, r0v, r1v, fwd1;
    lzo1x_pkg::result_t r0, r1;
    logic [AW-1:0] src;
    logic [15:0]   dmod;
    logic [7:0]    b;
    logic [7:0]    wd2;
    logic [31:0]   offv, dv;
    logic          done;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] c);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, c};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [31:0] cext(input logic [COUNT_BITS-1:0] v);
        return 32'(v);
    endfunction

    // output queue
    lzo1x_pkg::result_t q_mem [8];
    logic [2:0] qrd_reg, qwr_reg;
    logic [3:0] qcnt_reg;
    logic       pop;
    logic [1:0] npush;
    lzo1x_pkg::result_t e0;

    assign acc      = s_tvalid && s_tready;
    assign s_tready = ({1'b0, qcnt_reg} + (v2_reg ? 5'd2 : 5'd0)) <= 5'd6;
    assign b        = s_tdata;

    always_comb begin
        dmod = (32'(dist_reg) >= WINDOW_BYTES) ? 16'(32'(dist_reg) - WINDOW_BYTES) : dist_reg;
        if (32'(wp_reg) >= 32'(dmod)) begin
            src = AW'(32'(wp_reg) - 32'(dmod));
        end else begin
            src = AW'(32'(wp_reg) + WINDOW_BYTES - 32'(dmod));
        end
    end

    always_comb begin
        phase_next = phase_reg; wp_next = wp_reg; bt_next = bt_reg;
        lit_next = lit_reg; cpy_next = cpy_reg; dist_next = dist_reg;
        tok_next = tok_reg; offlo_next = offlo_reg; trl_next = trl_reg;
        alr_next = alr_reg;
        we1 = 1'b0; rd1 = 1'b0; mem1 = 1'b0; r0v = 1'b0; r1v = 1'b0;
        r0 = '0; r1 = '0; done = 1'b0;
        offv = '0; dv = '0;
        fwd1 = v2_reg && we2_reg && (wa2_reg == src);
        if (acc && s_tuser == lzo1x_pkg::OP_TICK) begin
            if (phase_reg == lzo1x_pkg::PH_COPY) begin
                rd1 = 1'b1; we1 = 1'b1; mem1 = 1'b1;
                wp_next = (wp_reg == WMAX) ? '0 : wp_reg + 1'b1;
                if (bt_reg != CLIM) bt_next = bt_reg + 1'b1;
                cpy_next = cpy_reg - 32'd1;
                if (cpy_reg == 32'd1) begin
                    if (trl_reg != 2'd0) begin
                        lit_next = 32'(trl_reg); alr_next = 1'b0;
                        phase_next = lzo1x_pkg::PH_LIT;
                    end else begin
                        phase_next = lzo1x_pkg::PH_TOK_A;
                    end
                end
                r0v = 1'b1;
                r0.kind = lzo1x_pkg::KIND_BYTE;
                r0.count = cext(bt_next);
                r0.pend = (phase_next == lzo1x_pkg::PH_COPY);
            end
        end else if (acc) begin
            unique case (phase_reg)
                lzo1x_pkg::PH_COPY: begin
                    done = 1'b1;
                    r0v = 1'b1; r0.kind = lzo1x_pkg::KIND_STATUS;
                    r0.status = lzo1x_pkg::ST_SEQ_ERR;
                end
                lzo1x_pkg::PH_FIRST, lzo1x_pkg::PH_TOK_A,
                lzo1x_pkg::PH_TOK_B, lzo1x_pkg::PH_TOK_C: begin
                    if (phase_reg == lzo1x_pkg::PH_FIRST && b > 8'd17) begin
                        lit_next = 32'(b - 8'd17);
                        alr_next = (b - 8'd17) >= 8'd4;
                        phase_next = lzo1x_pkg::PH_LIT;
                    end else begin
                        tok_next = b;
                        if (b >= 8'd64) begin
                            phase_next = lzo1x_pkg::PH_SHORTOFF;
                        end else if (b >= 8'd32) begin
                            cpy_next = (b[4:0] != 0) ? 32'(b[4:0]) + 32'd2 : 32'd33;
                            phase_next = (b[4:0] != 0) ? lzo1x_pkg::PH_OFFLO
                                                       : lzo1x_pkg::PH_MEXT;
                        end else if (b >= 8'd16) begin
                            cpy_next = (b[2:0] != 0) ? 32'(b[2:0]) + 32'd2 : 32'd9;
                            phase_next = (b[2:0] != 0) ? lzo1x_pkg::PH_OFFLO
                                                       : lzo1x_pkg::PH_MEXT;
                        end else if (phase_reg == lzo1x_pkg::PH_TOK_A ||
                                     phase_reg == lzo1x_pkg::PH_FIRST) begin
                            alr_next = 1'b1;
                            if (b == 8'd0) begin
                                lit_next = 32'd18; phase_next = lzo1x_pkg::PH_LITEXT;
                            end else begin
                                lit_next = 32'(b) + 32'd3; phase_next = lzo1x_pkg::PH_LIT;
                            end
                        end else begin
                            alr_next = (phase_reg == lzo1x_pkg::PH_TOK_B);
                            phase_next = lzo1x_pkg::PH_SHORTOFF;
                        end
                    end
                end
                lzo1x_pkg::PH_LITEXT: begin
                    lit_next = sat_add(lit_reg, (b == 8'd0) ? 32'd255 : 32'(b));
                    if (b != 8'd0) phase_next = lzo1x_pkg::PH_LIT;
                end
                lzo1x_pkg::PH_LIT: begin
                    we1 = 1'b1;
                    wp_next = (wp_reg == WMAX) ? '0 : wp_reg + 1'b1;
                    if (bt_reg != CLIM) bt_next = bt_reg + 1'b1;
                    lit_next = lit_reg - 32'd1;
                    if (lit_reg == 32'd1) begin
                        phase_next = alr_reg ? lzo1x_pkg::PH_TOK_B : lzo1x_pkg::PH_TOK_C;
                    end
                    r0v = 1'b1; r0.kind = lzo1x_pkg::KIND_BYTE; r0.data = b;
                    r0.count = cext(bt_next);
                end
                lzo1x_pkg::PH_MEXT: begin
                    cpy_next = sat_add(cpy_reg, (b == 8'd0) ? 32'd255 : 32'(b));
                    if (b != 8'd0) phase_next = lzo1x_pkg::PH_OFFLO;
                end
                lzo1x_pkg::PH_OFFLO: begin
                    offlo_next = b;
                    phase_next = lzo1x_pkg::PH_OFFHI;
                end
                lzo1x_pkg::PH_OFFHI: begin
                    offv = 32'({b, offlo_reg} >> 2);
                    trl_next = offlo_reg[1:0];
                    if (tok_reg >= 8'd32) begin
                        dist_next = 16'(32'd1 + offv);
                        phase_next = lzo1x_pkg::PH_COPY;
                    end else begin
                        dv = 32'({tok_reg[3], 14'd0}) + offv;
                        if (dv == 32'd0) begin
                            done = 1'b1;
                            r0v = 1'b1; r0.kind = lzo1x_pkg::KIND_STATUS;
                            r0.status = s_tlast ? lzo1x_pkg::ST_OK : lzo1x_pkg::ST_NOT_DONE;
                        end else begin
                            dist_next = 16'(dv + 32'h4000);
                            phase_next = lzo1x_pkg::PH_COPY;
                        end
                    end
                end
                lzo1x_pkg::PH_SHORTOFF: begin
                    trl_next = tok_reg[1:0];
                    phase_next = lzo1x_pkg::PH_COPY;
                    if (tok_reg >= 8'd64) begin
                        cpy_next = 32'(tok_reg[7:5]) + 32'd1;
                        dist_next = 16'd1 + 16'(tok_reg[4:2]) + {5'd0, b, 3'd0};
                    end else if (alr_reg) begin
                        cpy_next = 32'd3;
                        dist_next = 16'h0801 + 16'(tok_reg[7:2]) + {6'd0, b, 2'd0};
                    end else begin
                        cpy_next = 32'd2;
                        dist_next = 16'd1 + 16'(tok_reg[7:2]) + {6'd0, b, 2'd0};
                    end
                end
                default: done = 1'b1;
            endcase
            if (!done && s_tlast) begin
                r1v = 1'b1; r1.kind = lzo1x_pkg::KIND_STATUS;
                r1.count = cext(bt_next);
                r1.status = (phase_next == lzo1x_pkg::PH_FIRST ||
                             phase_next == lzo1x_pkg::PH_TOK_A ||
                             phase_next == lzo1x_pkg::PH_TOK_B ||
                             phase_next == lzo1x_pkg::PH_TOK_C) ?
                            lzo1x_pkg::ST_NO_END : lzo1x_pkg::ST_TRUNCATED;
                done = 1'b1;
            end
        end
        if (done) begin
            phase_next = lzo1x_pkg::PH_FIRST; bt_next = '0; lit_next = '0;
            cpy_next = '0; dist_next = '0; tok_next = '0; offlo_next = '0;
            trl_next = '0; alr_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= lzo1x_pkg::PH_FIRST;
            wp_reg <= '0; bt_reg <= '0; lit_reg <= '0; cpy_reg <= '0;
            dist_reg <= '0; tok_reg <= '0; offlo_reg <= '0; trl_reg <= '0;
            alr_reg <= 1'b0; v2_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next; wp_reg <= wp_next; bt_reg <= bt_next;
            lit_reg <= lit_next; cpy_reg <= cpy_next; dist_reg <= dist_next;
            tok_reg <= tok_next; offlo_reg <= offlo_next; trl_reg <= trl_next;
            alr_reg <= alr_next; v2_reg <= acc;
        end
    end

    always_ff @(posedge aclk) begin
        we2_reg <= we1; mem2_reg <= mem1; fwd2_reg <= fwd1; wa2_reg <= wp_reg;
        lit2_reg <= b; fwdd_reg <= wd2;
        r0_reg <= r0; r1_reg <= r1; r0v_reg <= r0v; r1v_reg <= r1v;
    end

    always_ff @(posedge aclk) begin
        if (rd1) rdata_reg <= window_mem[src];
        if (v2_reg && we2_reg) window_mem[wa2_reg] <= wd2;
    end

    assign wd2 = !mem2_reg ? lit2_reg : (fwd2_reg ? fwdd_reg : rdata_reg);

    always_comb begin
        e0 = r0_reg;
        if (r0v_reg && r0_reg.kind == lzo1x_pkg::KIND_BYTE) e0.data = wd2;
        if (!r0v_reg) e0 = r1_reg;
        npush = v2_reg ? (2'(r0v_reg) + 2'(r1v_reg)) : 2'd0;
    end

    assign pop = m_tvalid && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qrd_reg <= '0; qwr_reg <= '0; qcnt_reg <= '0;
        end else begin
            qwr_reg  <= qwr_reg + 3'(npush);
            qrd_reg  <= qrd_reg + 3'(pop);
            qcnt_reg <= qcnt_reg + 4'(npush) - 4'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (npush != 2'd0) q_mem[qwr_reg] <= e0;
        if (npush == 2'd2) q_mem[qwr_reg + 3'd1] <= r1_reg;
    end

    assign m_tvalid = qcnt_reg != 4'd0;
    assign m_tuser  = q_mem[qrd_reg].kind;
    assign m_tdata  = {4'd0, q_mem[qrd_reg].pend, q_mem[qrd_reg].count,
                       q_mem[qrd_reg].status, q_mem[qrd_reg].data};

endmodule

[sv/lzo1x_checker.sv]
// ----------------------------------------------------------------------------
// lzo1x_checker
// Port-level checks on the decompressor result stream.
// ----------------------------------------------------------------------------
module lzo1x_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[10:8] <= lzo1x_pkg::ST_SEQ_ERR))
        else $error("status code out of range");

    a_status_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (!m_tdata[43] && m_tdata[7:0] == 8'd0))
        else $error("status transaction with byte or pending copy");

    a_byte_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
            (m_tdata[10:8] == lzo1x_pkg::ST_OK && m_tdata[42:11] != 32'd0))
        else $error("byte transaction with status or zero count");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind lzo1x_stream_decompressor_core lzo1x_checker u_lzo1x_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
